// File: src/cdcs_pkg.sv
`default_nettype none
package cdcs_pkg;

  localparam int unsigned ChannelsDef = 256;
  localparam int unsigned TapsDef = 4;
  localparam int unsigned ChW = 8;
  localparam int unsigned ValW = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_BIAS   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ChW-1:0]     channel;
    logic [1:0]         tap;
    logic signed [ValW-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_READ   = 3'd1,
    ST_MAC    = 3'd2,
    ST_ROUND  = 3'd3,
    ST_SIGM   = 3'd4,
    ST_MUL    = 3'd5,
    ST_OUT    = 3'd6
  } state_e;

  function automatic logic [11:0] sig_lut(input logic [5:0] i);
    logic [11:0] r;
    begin
      case (i)
        6'd0: r = 12'd2048;  6'd1: r = 12'd2303;  6'd2: r = 12'd2550;
        6'd3: r = 12'd2782;  6'd4: r = 12'd2994;  6'd5: r = 12'd3184;
        6'd6: r = 12'd3349;  6'd7: r = 12'd3490;  6'd8: r = 12'd3608;
        6'd9: r = 12'd3705;  6'd10: r = 12'd3785; 6'd11: r = 12'd3850;
        6'd12: r = 12'd3902; 6'd13: r = 12'd3943; 6'd14: r = 12'd3976;
        6'd15: r = 12'd4002; 6'd16: r = 12'd4022; 6'd17: r = 12'd4038;
        6'd18: r = 12'd4051; 6'd19: r = 12'd4061; 6'd20: r = 12'd4069;
        6'd21: r = 12'd4075; 6'd22: r = 12'd4079; 6'd23: r = 12'd4083;
        6'd24: r = 12'd4086; 6'd25: r = 12'd4088; 6'd26: r = 12'd4090;
        6'd27: r = 12'd4091; 6'd28: r = 12'd4092; 6'd29: r = 12'd4093;
        6'd30: r = 12'd4094; 6'd31: r = 12'd4094;
        default: r = 12'd4095;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// File: src/cdcs_front.sv
`default_nettype none
module cdcs_front
  import cdcs_pkg::*;
#(
  parameter int unsigned Channels = ChannelsDef,
  parameter int unsigned Taps = TapsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire cmd_t in_cmd_i,
  output logic      q_valid_o,
  input  wire logic q_ready_i,
  output cmd_t      q_cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t             mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             keep, push, pop;

  always_comb begin
    keep = (32'(in_cmd_i.channel) < Channels) && (in_cmd_i.kind != KIND_NONE) &&
           !(in_cmd_i.kind == KIND_WEIGHT && 32'(in_cmd_i.tap) >= Taps);
    in_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
    push = in_valid_i && in_ready_o && keep;
    q_valid_o = (cnt_q != '0);
    pop = q_valid_o && q_ready_i;
    q_cmd_o = mem_q[rd_q];
    wr_d = push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d = pop ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QueueDepth)) else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> !pop) else $error("pop on empty");
  a_drop_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_cmd_i.kind == KIND_NONE) |-> !push) else $error("kind 3 queued");
`endif

endmodule
`default_nettype wire

// File: src/cdcs_back.sv
`default_nettype none
module cdcs_back
  import cdcs_pkg::*;
#(
  parameter int unsigned Channels = ChannelsDef,
  parameter int unsigned Taps = TapsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  output logic      q_ready_o,
  input  wire cmd_t q_cmd_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [ChW-1:0] out_channel_o,
  output logic [ValW-1:0] out_activated_o,
  output logic      out_saturated_o
);

  localparam int unsigned AW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned TW = (Taps > 1) ? $clog2(Taps) : 1;
  localparam int unsigned HN = Taps - 1;
  localparam int unsigned HW = (HN > 1) ? $clog2(HN) : 1;
  localparam int unsigned CW = $clog2(Channels + 1);
  localparam int unsigned AccW = 36;

  logic signed [ValW-1:0] wmem [Channels][Taps];
  logic signed [ValW-1:0] bmem [Channels];
  logic signed [ValW-1:0] hmem [Channels][HN];

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic [AW-1:0] addr;
  logic signed [ValW-1:0] w_rd_q [Taps];
  logic signed [ValW-1:0] h_rd_q [HN];
  logic signed [ValW-1:0] b_rd_q;
  logic [TW-1:0] k_q, k_d;
  logic [HW-1:0] hk;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [ValW-1:0] v_q, v_d;
  logic [11:0] s_q, s_d;
  logic signed [31:0] prod_q, prod_d;
  logic sat_q, sat_d;
  logic [ValW-1:0] res_q, res_d;
  logic [ChW-1:0] och_q;
  logic [CW-1:0] clr_q;
  logic clearing;
  logic take, we_hist;
  logic signed [ValW-1:0] xk;
  logic signed [AccW-1:0] rnd;
  logic [ValW-1:0] absv;
  logic [5:0] si;
  logic [9:0] sf;
  logic [11:0] t0, t1, sp;
  logic [21:0] dprod;
  logic signed [31:0] r32;

  assign addr = cmd_q.channel[AW-1:0];
  assign clearing = (clr_q != CW'(Channels));
  assign q_ready_o = (state_q == ST_IDLE) && !clearing;
  assign take = q_valid_i && q_ready_o;

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    acc_d = acc_q;
    v_d = v_q;
    s_d = s_q;
    prod_d = prod_q;
    sat_d = sat_q;
    res_d = res_q;
    we_hist = 1'b0;
    hk = (k_q == '0) ? '0 : HW'(k_q - 1'b1);
    xk = (k_q == '0) ? cmd_q.value : h_rd_q[hk];
    rnd = acc_q + AccW'(2048);
    rnd = rnd >>> 12;
    absv = v_q[ValW-1] ? ValW'(-v_q) : v_q;
    si = absv[15:10];
    sf = absv[9:0];
    t0 = sig_lut(si);
    t1 = sig_lut(6'(si + 6'd1));
    dprod = 22'(t1 - t0) * 22'(sf) + 22'd512;
    sp = (si >= 6'd32) ? sig_lut(6'd32) : 12'(t0 + 12'(dprod >> 10));
    r32 = (prod_q + 32'sd2048) >>> 12;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          state_d = (q_cmd_i.kind == KIND_SAMPLE) ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_MAC;
        k_d = '0;
        acc_d = AccW'(b_rd_q) <<< 12;
        sat_d = 1'b0;
      end
      ST_MAC: begin
        acc_d = acc_q + AccW'(w_rd_q[k_q] * xk);
        if (32'(k_q) == Taps - 1) begin
          state_d = ST_ROUND;
        end else begin
          k_d = TW'(k_q + 1'b1);
        end
      end
      ST_ROUND: begin
        if (rnd > AccW'(32767)) begin
          v_d = 16'sh7fff;
          sat_d = 1'b1;
        end else if (rnd < -AccW'(32768)) begin
          v_d = -16'sh8000;
          sat_d = 1'b1;
        end else begin
          v_d = ValW'(rnd);
        end
        we_hist = 1'b1;
        state_d = ST_SIGM;
      end
      ST_SIGM: begin
        s_d = v_q[ValW-1] ? 12'(13'd4096 - 13'(sp)) : sp;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = 32'(v_q) * $signed({20'd0, s_q});
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_d = ValW'(r32);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clr_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (state_q == ST_OUT) begin
        state_q <= out_valid_o && !out_ready_i ? ST_OUT : state_d;
        if (!(out_valid_o && !out_ready_i)) out_valid_o <= 1'b1;
      end else begin
        state_q <= state_d;
        if (out_ready_i) out_valid_o <= 1'b0;
      end
      if (clearing) clr_q <= CW'(clr_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= q_cmd_i;
    k_q <= k_d;
    acc_q <= acc_d;
    v_q <= v_d;
    s_q <= s_d;
    prod_q <= prod_d;
    if (!(state_q == ST_OUT && out_valid_o && !out_ready_i)) begin
      sat_q <= sat_d;
      res_q <= res_d;
      if (state_q == ST_OUT) begin
        out_channel_o <= cmd_q.channel;
        out_activated_o <= res_d;
        out_saturated_o <= sat_q;
        och_q <= cmd_q.channel;
      end
    end
    if (take) begin
      for (int t = 0; t < Taps; t++) w_rd_q[t] <= wmem[q_cmd_i.channel[AW-1:0]][t];
      for (int t = 0; t < HN; t++) h_rd_q[t] <= hmem[q_cmd_i.channel[AW-1:0]][t];
      b_rd_q <= bmem[q_cmd_i.channel[AW-1:0]];
      if (q_cmd_i.kind == KIND_WEIGHT) wmem[q_cmd_i.channel[AW-1:0]][q_cmd_i.tap[TW-1:0]] <= q_cmd_i.value;
      if (q_cmd_i.kind == KIND_BIAS) bmem[q_cmd_i.channel[AW-1:0]] <= q_cmd_i.value;
    end
    if (clearing) begin
      for (int t = 0; t < HN; t++) hmem[clr_q[AW-1:0]][t] <= '0;
    end else if (we_hist) begin
      hmem[addr][0] <= cmd_q.value;
      for (int t = 1; t < HN; t++) hmem[addr][t] <= h_rd_q[t-1];
    end
  end

`ifndef ASSERT_OFF
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> state_q == ST_IDLE) else $error("work during clear");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_channel_o == $past(out_channel_o))
    else $error("output changed while stalled");
  a_hist_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_hist |-> cmd_q.kind == KIND_SAMPLE) else $error("history write without sample");
  a_och: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_channel_o == och_q) else $error("channel mismatch");
`endif

endmodule
`default_nettype wire

// File: src/causal_depthwise_conv_silu_top.sv
// channel | direction | payload
// s_axis  | in        | tdata: kind[1:0] channel[9:2] tap[11:10] value[27:12]
// m_axis  | out       | tdata: out_channel[7:0] activated[23:8] saturated[24]
// A sample item passes through the back-end states READ, MAC (one multiply-add per tap), ROUND, SIGM, MUL and OUT.
// Weight and bias items are written when taken, without leaving the idle state; a two-entry queue sits in front.
// After reset the history memory is cleared one channel per cycle before items leave the queue.
// The result register holds while m_axis_tvalid is high and m_axis_tready is low; this stalls the back end in ST_OUT.
`default_nettype none
module causal_depthwise_conv_silu_top
  import cdcs_pkg::*;
#(
  parameter int unsigned Channels = ChannelsDef,
  parameter int unsigned Taps = TapsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // kind, channel, tap, value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // out_channel, activated, saturated
);

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [ChW-1:0] och;
  logic [ValW-1:0] act;
  logic sat;

  assign in_cmd.kind = kind_e'(s_axis_tdata[1:0]);
  assign in_cmd.channel = s_axis_tdata[9:2];
  assign in_cmd.tap = s_axis_tdata[11:10];
  assign in_cmd.value = s_axis_tdata[27:12];
  assign m_axis_tdata = {7'd0, sat, act, och};

  cdcs_front #(.Channels(Channels), .Taps(Taps)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  cdcs_back #(.Channels(Channels), .Taps(Taps)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_channel_o(och), .out_activated_o(act), .out_saturated_o(sat)
  );

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cdcs_pkg::*;

  localparam int NumItems = 1050;
  localparam int CycleLimit = 400000;

  class ConvSiluScoreboard;
    shortint hist[256][3];
    shortint wt[256][4];
    shortint bias[256];
    logic [24:0] pending[$];
    int errors;

    function new();
      errors = 0;
      foreach (hist[c, k]) hist[c][k] = 0;
    endfunction

    function longint clip16(longint x, ref bit sat);
      if (x > 32767) begin
        sat = 1;
        return 32767;
      end
      if (x < -32768) begin
        sat = 1;
        return -32768;
      end
      return x;
    endfunction

    function longint sigmoid_q12(longint v);
      longint sig_tab[33] = '{2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490,
                              3608, 3705, 3785, 3850, 3902, 3943, 3976, 4002,
                              4022, 4038, 4051, 4061, 4069, 4075, 4079, 4083,
                              4086, 4088, 4090, 4091, 4092, 4093, 4094, 4094,
                              4095};
      longint a, i, f, s;
      a = (v < 0) ? -v : v;
      i = a >> 10;
      f = a & 1023;
      if (i >= 32) s = sig_tab[32];
      else s = sig_tab[i] + (((sig_tab[i+1] - sig_tab[i]) * f + 512) >> 10);
      return (v < 0) ? 4096 - s : s;
    endfunction

    function void note_item(kind_e kind, int ch, int tap, shortint val);
      longint acc, v, r;
      bit sat;
      case (kind)
        KIND_WEIGHT: wt[ch][tap] = val;
        KIND_BIAS: bias[ch] = val;
        KIND_SAMPLE: begin
          sat = 0;
          acc = longint'(bias[ch]) * 4096 + longint'(wt[ch][0]) * longint'(val);
          for (int k = 1; k < 4; k++) acc += longint'(wt[ch][k]) * longint'(hist[ch][k-1]);
          v = clip16((acc + 2048) >>> 12, sat);
          r = clip16((v * sigmoid_q12(v) + 2048) >>> 12, sat);
          hist[ch][2] = hist[ch][1];
          hist[ch][1] = hist[ch][0];
          hist[ch][0] = val;
          pending.push_back({sat, r[15:0], ch[7:0]});
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] d);
      logic [24:0] e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[7:0] !== e[7:0]) begin
        $error("out_channel expected %0d actual %0d", e[7:0], d[7:0]);
        errors++;
      end
      if (d[23:8] !== e[23:8]) begin
        $error("activated expected %0d actual %0d", $signed(e[23:8]), $signed(d[23:8]));
        errors++;
      end
      if (d[24] !== e[24]) begin
        $error("saturated expected %0d actual %0d", e[24], d[24]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;

  ConvSiluScoreboard sb = new();
  bit [4:0] wmask[256];
  int ready_ch[$];
  int burst_left = 0;
  int last_ch = 0;
  int cycles = 0;

  causal_depthwise_conv_silu_top u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    int mode, hold;
    mode = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (cycles == 5000) hold = 700;
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      if (hold > 0) begin
        hold--;
        m_axis_tready = 0;
      end else begin
        case (mode)
          0: m_axis_tready = 1;
          1: m_axis_tready = ($urandom_range(0, 1) == 1);
          2: m_axis_tready = ($urandom_range(0, 9) != 0);
          default: m_axis_tready = ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  function automatic shortint rand_val(bit narrow);
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return shortint'($urandom);
      default: return narrow ? shortint'($signed($urandom_range(0, 8192)) - 4096)
                             : shortint'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic push_item(kind_e k, int ch, int tap, shortint v);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk_i);
        s_axis_tvalid = 0;
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1;
    s_axis_tdata = {4'b0, v, tap[1:0], ch[7:0], k};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(k, ch, tap, v);
    if (k == KIND_WEIGHT) wmask[ch][tap] = 1;
    if (k == KIND_BIAS) wmask[ch][4] = 1;
    if (k != KIND_SAMPLE && k != KIND_NONE && wmask[ch] == 5'h1f) begin
      ready_ch.push_back(ch);
      wmask[ch] = 0;
      wmask[ch][4] = 1;
      wmask[ch] = 5'h1e;
    end
  endtask

  task automatic setup_channel(int ch, shortint w, shortint b);
    for (int t = 0; t < 4; t++) push_item(KIND_WEIGHT, ch, t, w);
    push_item(KIND_BIAS, ch, 0, b);
  endtask

  initial begin
    int r, ch;
    bit found;
    foreach (wmask[c]) wmask[c] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    push_item(KIND_NONE, 5, 3, 16'sh7fff);
    setup_channel(0, 16'sh7fff, 16'sh7fff);
    push_item(KIND_SAMPLE, 0, 0, 16'sh7fff);
    push_item(KIND_SAMPLE, 0, 0, 16'sh8000);
    setup_channel(255, 16'sh8000, 16'sh8000);
    push_item(KIND_SAMPLE, 255, 3, 16'sh8000);
    push_item(KIND_SAMPLE, 255, 0, 16'sh7fff);
    setup_channel(1, 16'sh1000, 16'sh0000);
    push_item(KIND_SAMPLE, 1, 0, 16'sh0000);
    push_item(KIND_SAMPLE, 1, 0, 16'sh7fff);
    push_item(KIND_SAMPLE, 1, 0, 16'sh8000);
    push_item(KIND_SAMPLE, 1, 0, 16'sh0400);
    push_item(KIND_SAMPLE, 1, 0, -16'sh0400);

    for (int n = 0; n < NumItems; n++) begin
      r = $urandom_range(0, 99);
      ch = (r < 50 && ready_ch.size() > 0) ? last_ch : $urandom_range(0, 255);
      if (ready_ch.size() < 12 || r < 12) begin
        push_item(KIND_WEIGHT, ch, $urandom_range(0, 3), rand_val(1));
      end else if (r < 20) begin
        push_item(KIND_BIAS, ch, $urandom_range(0, 3), rand_val(1));
      end else if (r < 24) begin
        push_item(KIND_NONE, ch, $urandom_range(0, 3), rand_val(0));
      end else begin
        found = 0;
        foreach (ready_ch[i]) if (ready_ch[i] == last_ch) found = 1;
        if (!found || $urandom_range(0, 9) < 6)
          last_ch = ready_ch[$urandom_range(0, ready_ch.size() - 1)];
        push_item(KIND_SAMPLE, last_ch, $urandom_range(0, 3), rand_val(0));
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: filelist.f
src/cdcs_pkg.sv
src/cdcs_front.sv
src/cdcs_back.sv
src/causal_depthwise_conv_silu_top.sv
sim/testbench.sv
